// ===== hw/rtl/depq_pkg.sv =====
// depq_pkg: shared types, constants and the ordering function for the
// double-ended priority queue. Used by every module of the block.
// No dependencies.
`default_nettype none

package depq_pkg;

    // Capacity and field widths
    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 16;
    localparam int VAL_W    = 32;

    // Stored entry: id and priority value
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [VAL_W-1:0] value;
    } entry_t;

    // Command codes on the input channel
    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP_MIN = 2'd1,
        CMD_POP_MAX = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    // Status codes on the result channel
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Operation broadcast to every cell of one chain
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP_HEAD,
        OP_DELETE,
        OP_CLEAR
    } op_t;

    // True when a sorts strictly ahead of b in a chain.
    // Min chain: value ascending. Max chain: value descending.
    // Both chains break ties by the smaller id.
    function automatic logic precedes(input entry_t a, input entry_t b,
                                      input logic order_max);
        logic res;
        if (a.value != b.value)
        begin
            res = order_max ? (a.value > b.value) : (a.value < b.value);
        end
        else
        begin
            res = (a.id < b.id);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/depq_cell.sv =====
// depq_cell: one slot of a sorted chain. Holds one entry and a valid bit,
// and takes its next entry from itself, a neighbor or the broadcast key.
// Depends on depq_pkg.
`default_nettype none

module depq_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            order_max,
    input  depq_pkg::op_t        op,
    input  depq_pkg::entry_t     key,
    input  depq_pkg::entry_t     left_entry,
    input  wire logic            left_valid,
    input  wire logic            left_gt,
    input  depq_pkg::entry_t     right_entry,
    input  wire logic            right_valid,
    output depq_pkg::entry_t     entry,
    output logic                 valid,
    output logic                 gt
);
    import depq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid_reg;
    logic   valid_next;
    logic   ge;

    // Key sorts ahead of this slot (empty slots sort last)
    assign gt = !valid_reg || precedes(key, entry_reg, order_max);
    // This slot sorts at or after the key
    assign ge = !valid_reg || !precedes(entry_reg, key, order_max);

    // Next slot contents
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        unique case (op)
            OP_INSERT:
            begin
                if (gt)
                begin
                    if (!left_gt)
                    begin
                        entry_next = key;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        entry_next = left_entry;
                        valid_next = left_valid;
                    end
                end
            end
            OP_POP_HEAD:
            begin
                entry_next = right_entry;
                valid_next = right_valid;
            end
            OP_DELETE:
            begin
                if (ge)
                begin
                    entry_next = right_entry;
                    valid_next = right_valid;
                end
            end
            OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                entry_next = entry_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Entry payload, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/depq_chain.sv =====
// depq_chain: row of CAPACITY cells kept sorted, head at cell 0.
// Order direction is chosen by order_max. Depends on depq_pkg, depq_cell.
`default_nettype none

module depq_chain (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            order_max,
    input  depq_pkg::op_t        op,
    input  depq_pkg::entry_t     key,
    output depq_pkg::entry_t     head
);
    import depq_pkg::*;

    entry_t entry_w [CAPACITY];
    logic   valid_w [CAPACITY];
    logic   gt_w    [CAPACITY];

    // Cell row with neighbor links
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t l_entry;
        logic   l_valid;
        logic   l_gt;
        entry_t r_entry;
        logic   r_valid;

        if (i == 0)
        begin : g_first
            assign l_entry = key;
            assign l_valid = 1'b0;
            assign l_gt    = 1'b0;
        end
        else
        begin : g_mid_l
            assign l_entry = entry_w[i-1];
            assign l_valid = valid_w[i-1];
            assign l_gt    = gt_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign r_entry = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_entry = entry_w[i+1];
            assign r_valid = valid_w[i+1];
        end

        depq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .order_max   (order_max),
            .op          (op),
            .key         (key),
            .left_entry  (l_entry),
            .left_valid  (l_valid),
            .left_gt     (l_gt),
            .right_entry (r_entry),
            .right_valid (r_valid),
            .entry       (entry_w[i]),
            .valid       (valid_w[i]),
            .gt          (gt_w[i])
        );
    end

    assign head = entry_w[0];

endmodule

`default_nettype wire

// ===== hw/rtl/double_ended_priority_queue.sv =====
// Double-ended priority queue top level: command decode, occupancy count,
// result register. Depends on depq_pkg and depq_chain.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transaction:
//   push (entry_id, entry_value), pop minimum, pop maximum or clear.
//   Output channel (out_valid/out_ready) returns one result per command:
//   removed entry (zero unless a pop succeeded), status and new count.
//   Pop minimum returns the smallest value, pop maximum the largest; both
//   break value ties by the smaller id. A pop on an empty queue or a push
//   into a full one is flagged in status and changes nothing.
//   Storage is two sorted chains of CAPACITY cells (ascending and
//   descending); every successful command updates both chains together through
//   a compare in each cell and a one-step shift to a neighbor.
//   The result is registered and valid the cycle after the command is accepted.
//   Throughput: one command per cycle while out_ready is high.
//   If the receiver stalls, the result is held and in_ready drops until
//   it is taken; the next command is accepted in the cycle it leaves.
//   Reset empties the queue and clears out_valid; the result payload is not reset.
`default_nettype none

module double_ended_priority_queue (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   cmd,
    input  wire logic [depq_pkg::ID_W-1:0]    entry_id,
    input  wire logic [depq_pkg::VAL_W-1:0]   entry_value,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [depq_pkg::ID_W-1:0]         out_id,
    output logic [depq_pkg::VAL_W-1:0]        out_value,
    output logic [1:0]                        status,
    output logic [depq_pkg::CNT_W-1:0]        count
);
    import depq_pkg::*;

    logic             accept;
    logic             full;
    logic             empty;
    cmd_t             cmd_in;
    entry_t           new_entry;
    entry_t           head_min;
    entry_t           head_max;
    op_t              op_min;
    op_t              op_max;
    entry_t           key_min;
    entry_t           key_max;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    entry_t           res_reg;
    entry_t           res_next;
    status_t          status_reg;
    status_t          status_next;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign cmd_in    = cmd_t'(cmd);
    assign new_entry = '{id: entry_id, value: entry_value};

    // Command decode
    always_comb
    begin
        op_min      = OP_HOLD;
        op_max      = OP_HOLD;
        key_min     = new_entry;
        key_max     = new_entry;
        res_next    = res_reg;
        status_next = status_reg;
        count_next  = count_reg;
        if (accept)
        begin
            res_next    = '0;
            status_next = ST_OK;
            unique case (cmd_in)
                CMD_PUSH:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        op_min     = OP_INSERT;
                        op_max     = OP_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_POP_MIN:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        op_min     = OP_POP_HEAD;
                        op_max     = OP_DELETE;
                        key_max    = head_min;
                        res_next   = head_min;
                        count_next = count_reg - 1'b1;
                    end
                end
                CMD_POP_MAX:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        op_max     = OP_POP_HEAD;
                        op_min     = OP_DELETE;
                        key_min    = head_max;
                        res_next   = head_max;
                        count_next = count_reg - 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    op_min     = OP_CLEAR;
                    op_max     = OP_CLEAR;
                    count_next = '0;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // Result register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        status_reg <= status_next;
    end

    // Ascending chain: head is the minimum
    depq_chain u_chain_min (
        .clk       (clk),
        .rst_n     (rst_n),
        .order_max (1'b0),
        .op        (op_min),
        .key       (key_min),
        .head      (head_min)
    );

    // Descending chain: head is the maximum
    depq_chain u_chain_max (
        .clk       (clk),
        .rst_n     (rst_n),
        .order_max (1'b1),
        .op        (op_max),
        .key       (key_max),
        .head      (head_max)
    );

    assign out_valid = out_valid_reg;
    assign out_id    = res_reg.id;
    assign out_value = res_reg.value;
    assign status    = status_reg;
    assign count     = count_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/depq_checker.sv =====
// depq_checker: port-level assertions for the double-ended priority queue,
// bound to the top level. Depends on depq_pkg.
`default_nettype none

module depq_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         in_ready,
    input  wire logic [1:0]                   cmd,
    input  wire logic [depq_pkg::ID_W-1:0]    entry_id,
    input  wire logic [depq_pkg::VAL_W-1:0]   entry_value,
    input  wire logic                         out_valid,
    input  wire logic                         out_ready,
    input  wire logic [depq_pkg::ID_W-1:0]    out_id,
    input  wire logic [depq_pkg::VAL_W-1:0]   out_value,
    input  wire logic [1:0]                   status,
    input  wire logic [depq_pkg::CNT_W-1:0]   count
);
    import depq_pkg::*;

    // Failed commands return no entry
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY || status == ST_FULL)
        |-> (out_id == '0) && (out_value == '0))
        else $error("failed command returned an entry");

    // Empty flag only with an empty queue
    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> count == '0)
        else $error("empty status with nonzero count");

    // Full flag only with a full queue
    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> count == CNT_W'(CAPACITY))
        else $error("full status without a full queue");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready
        |=> out_valid && $stable(out_value) && $stable(count))
        else $error("stalled result changed");

endmodule

bind double_ended_priority_queue depq_checker u_depq_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for double_ended_priority_queue.
// Holds its own model of the queue in a small scoreboard class and drives
// both valid/ready channels with random idling. Depends on depq_pkg.

module tb;

    import depq_pkg::*;

    localparam int STALL_LIMIT = 2000;  // cycles without any transaction
    localparam int LONG_HOLD   = 300;   // receiver hold-off that backs up the input
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 150;

    // Expected content of one result transaction
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [VAL_W-1:0] value;
        status_t          status;
        logic [CNT_W-1:0] count;
    } result_t;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } phase_kind_t;

    // Scoreboard: tracks queue content and the results still owed
    class depq_scoreboard;
        entry_t  slots[CAPACITY];
        int      held;
        result_t awaited[$];
        int      failures;

        function new();
            held = 0;
            failures = 0;
        endfunction

        // a wins over b: better value, ties go to the smaller id
        function bit ranks_ahead(entry_t a, entry_t b, bit want_max);
            if (a.value != b.value)
            begin
                return want_max ? (a.value > b.value) : (a.value < b.value);
            end
            return a.id < b.id;
        endfunction

        // Apply one command to the queue contents, return its result
        function result_t apply_command(cmd_t op, entry_t e);
            result_t r;
            int best;
            int i;
            r = '0;
            r.status = ST_OK;
            case (op)
                CMD_PUSH:
                begin
                    if (held >= CAPACITY)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        slots[held] = e;
                        held++;
                    end
                end
                CMD_CLEAR:
                begin
                    held = 0;
                end
                default:
                begin
                    if (held == 0)
                    begin
                        r.status = ST_EMPTY;
                    end
                    else
                    begin
                        best = 0;
                        for (i = 1; i < held; i++)
                        begin
                            if (ranks_ahead(slots[i], slots[best], op == CMD_POP_MAX))
                            begin
                                best = i;
                            end
                        end
                        r.id = slots[best].id;
                        r.value = slots[best].value;
                        held--;
                        slots[best] = slots[held];
                    end
                end
            endcase
            r.count = held[CNT_W-1:0];
            return r;
        endfunction

        // Queue the expected result at the tail
        function void note_command(cmd_t op, entry_t e);
            awaited.insert(awaited.size(), apply_command(op, e));
        endfunction

        function void check_result(logic [ID_W-1:0] id, logic [VAL_W-1:0] value,
                                   logic [1:0] st, logic [CNT_W-1:0] cnt);
            result_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result: id %0h value %0h status %0d count %0d",
                         $time, id, value, st, cnt);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (id !== want.id)
            begin
                $display("%0t: out_id expected %0h actual %0h", $time, want.id, id);
                failures++;
            end
            if (value !== want.value)
            begin
                $display("%0t: out_value expected %0h actual %0h", $time, want.value, value);
                failures++;
            end
            if (st !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
                failures++;
            end
            if (cnt !== want.count)
            begin
                $display("%0t: count expected %0d actual %0d", $time, want.count, cnt);
                failures++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [1:0]       cmd;
    logic [ID_W-1:0]  entry_id;
    logic [VAL_W-1:0] entry_value;
    logic             out_valid;
    logic             out_ready;
    logic [ID_W-1:0]  out_id;
    logic [VAL_W-1:0] out_value;
    logic [1:0]       status;
    logic [CNT_W-1:0] count;

    depq_scoreboard sb;
    bit             gaps_on;
    bit             stalls_on;
    bit             hold_request;
    int             quiet_cycles;

    double_ended_priority_queue i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .entry_id    (entry_id),
        .entry_value (entry_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_id      (out_id),
        .out_value   (out_value),
        .status      (status),
        .count       (count)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_PUSH;
        entry_id = '0;
        entry_value = '0;
        out_ready = 1'b0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        hold_request = 1'b0;
        quiet_cycles = 0;
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    always #1 clk = ~clk;

    // Receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int n;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (stalls_on && $urandom_range(0, 11) == 0)
            begin
                n = $urandom_range(1, 9);
                out_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(out_id, out_value, status, count);
        end
    end

    // Watchdog: ends the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one command and hold it until the handshake
    task automatic send_command(cmd_t op, logic [ID_W-1:0] id, logic [VAL_W-1:0] value);
        entry_t e;
        e.id = id;
        e.value = value;
        @(negedge clk);
        in_valid <= 1'b1;
        cmd <= op;
        entry_id <= id;
        entry_value <= value;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_command(op, e);
    endtask

    // Drop valid and pause the sender, with n setting the length of the pause
    task automatic pause_sender(int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Sender goes quiet until every owed result has arrived
    task automatic await_results();
        pause_sender(1);
        while (sb.pending() > 0)
        begin
            @(posedge clk);
        end
    endtask

    // Random command stream; the phase kind steers the push/pop balance
    task automatic run_phase(phase_kind_t kind);
        int push_pct;
        int roll;
        int k;
        cmd_t op;
        logic [ID_W-1:0] id;
        logic [VAL_W-1:0] value;
        push_pct = (kind == PH_FILL) ? 80 : (kind == PH_DRAIN) ? 15 : 48;
        for (k = 0; k < PHASE_ITEMS; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll == 0)
            begin
                op = CMD_CLEAR;
            end
            else if (roll <= push_pct)
            begin
                op = CMD_PUSH;
            end
            else
            begin
                op = ($urandom_range(0, 1) == 0) ? CMD_POP_MIN : CMD_POP_MAX;
            end
            // narrow ranges often, so values tie and ids repeat
            case ($urandom_range(0, 3))
                0: value = $urandom;
                1: value = $urandom_range(0, 7);
                2: value = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'h0;
                default: value = $urandom_range(0, 255);
            endcase
            id = ($urandom_range(0, 1) == 0) ? ID_W'($urandom_range(0, 65535))
                                             : ID_W'($urandom_range(0, 7));
            send_command(op, id, value);
            if (gaps_on && $urandom_range(0, 9) == 0)
            begin
                pause_sender($urandom_range(1, 9));
            end
        end
    endtask

    // Main sequence
    initial
    begin
        int p;
        phase_kind_t kind;
        wait (rst_n);
        @(posedge clk);

        // Directed: empty pops, extremes, value ties, duplicates, clear
        send_command(CMD_POP_MIN, 16'h0000, 32'h0000_0000);
        send_command(CMD_POP_MAX, 16'hFFFF, 32'hFFFF_FFFF);
        send_command(CMD_CLEAR,   16'h1234, 32'h0000_0001);
        send_command(CMD_PUSH,    16'hFFFF, 32'hFFFF_FFFF);
        send_command(CMD_PUSH,    16'h0000, 32'h0000_0000);
        send_command(CMD_PUSH,    16'h8000, 32'h0000_0005);
        send_command(CMD_PUSH,    16'h0003, 32'h0000_0005);
        send_command(CMD_PUSH,    16'h0001, 32'hFFFF_FFFF);
        send_command(CMD_PUSH,    16'hAAAA, 32'h5555_5555);
        send_command(CMD_PUSH,    16'h5555, 32'hAAAA_AAAA);
        send_command(CMD_PUSH,    16'h8000, 32'h0000_0005);
        send_command(CMD_POP_MAX, 16'h0000, 32'h0000_0000);
        send_command(CMD_POP_MAX, 16'h0000, 32'h0000_0000);
        send_command(CMD_POP_MIN, 16'h0000, 32'h0000_0000);
        send_command(CMD_POP_MIN, 16'h0000, 32'h0000_0000);
        send_command(CMD_POP_MIN, 16'h0000, 32'h0000_0000);
        send_command(CMD_POP_MIN, 16'h0000, 32'h0000_0000);
        send_command(CMD_CLEAR,   16'h0000, 32'h0000_0000);
        send_command(CMD_POP_MAX, 16'h0000, 32'h0000_0000);
        send_command(CMD_PUSH,    16'h7FFF, 32'h8000_0000);
        send_command(CMD_POP_MAX, 16'hFFFF, 32'hFFFF_FFFF);

        // Random phases: a push-heavy fill phase first, then a pop-heavy drain phase
        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 0)
            begin
                kind = PH_FILL;
            end
            else if (p == 1)
            begin
                kind = PH_DRAIN;
            end
            else
            begin
                kind = phase_kind_t'($urandom_range(0, 2));
            end
            if (p == 3)
            begin
                hold_request = 1'b1;
            end
            if (p >= NUM_PHASES - 2)
            begin
                gaps_on = 1'b0;
                stalls_on = 1'b0;
            end
            run_phase(kind);
            if (p == 2 || p == 5 || p == 8)
            begin
                await_results();
            end
        end

        // Drain and let the pipeline settle
        await_results();
        repeat (4) @(posedge clk);
        if (sb.failures == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== double_ended_priority_queue.f =====
hw/rtl/depq_pkg.sv
hw/rtl/depq_cell.sv
hw/rtl/depq_chain.sv
hw/rtl/double_ended_priority_queue.sv
hw/rtl/depq_checker.sv
tb/tb.sv
